/* rtl/gse_pkg.sv */
// shared constants, types and control encodings of the gray sobel edge filter
package gse_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int DimW       = 11;
  localparam int RowW       = 11;
  localparam int GrayW      = 8;
  localparam int SumW       = 15;
  localparam int RecipW     = 13;
  localparam int RecipShift = 19;
  localparam int AbsW       = 10;
  localparam int MagW       = 21;
  localparam int RootW      = 11;
  localparam int IdxW       = 4;
  localparam int CfgIdxW    = 8;

  // floor(x / 100) == (x * Recip100) >> RecipShift for every gray sum
  localparam logic [RecipW-1:0] Recip100 = RecipW'(5243);

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_GRAY,
    S_WIN,
    S_GRAD,
    S_SQ,
    S_SQRT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic take_item;
    logic gray_load;
    logic win_update;
    logic grad_load;
    logic sq_load;
    logic sqrt_step;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic emit;
    logic border;
    logic sqrt_done;
  } dp_sts_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    r = v;
    if (v < DimW'(3)) r = DimW'(3);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

/* rtl/gse_ctrl.sv */
// sequencer for one item at a time: buffer clear, gray, window, gradient, square, square root, output
module gse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  output logic              out_load_o,
  output gse_pkg::dp_cmd_t  cmd_o,
  input  gse_pkg::dp_sts_t  sts_i
);

  gse_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gse_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      gse_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = gse_pkg::S_IDLE;
      end
      gse_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d         = gse_pkg::S_GRAY;
        end
      end
      gse_pkg::S_GRAY: begin
        cmd_o.gray_load = 1'b1;
        state_d         = gse_pkg::S_WIN;
      end
      gse_pkg::S_WIN: begin
        cmd_o.win_update = 1'b1;
        if (!sts_i.emit) state_d = gse_pkg::S_IDLE;
        else if (sts_i.border) state_d = gse_pkg::S_OUT;
        else state_d = gse_pkg::S_GRAD;
      end
      gse_pkg::S_GRAD: begin
        cmd_o.grad_load = 1'b1;
        state_d         = gse_pkg::S_SQ;
      end
      gse_pkg::S_SQ: begin
        cmd_o.sq_load = 1'b1;
        state_d       = gse_pkg::S_SQRT;
      end
      gse_pkg::S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_done) state_d = gse_pkg::S_OUT;
      end
      gse_pkg::S_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = gse_pkg::S_IDLE;
        end
      end
      default: state_d = gse_pkg::S_CLEAR;
    endcase
  end

endmodule

/* rtl/gse_dp.sv */
// datapath: line buffers, 3x3 window, raster position, gradient and square root unit
module gse_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gse_pkg::dp_cmd_t            cmd_i,
  output gse_pkg::dp_sts_t            sts_o,
  input  logic                        restart_i,
  input  logic [gse_pkg::DimW-1:0]    w_i,
  input  logic [gse_pkg::DimW-1:0]    h_i,
  input  logic [7:0]                  red_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  blue_i,
  input  logic                        flush_i,
  output logic [gse_pkg::GrayW-1:0]   edge_value_o,
  output logic                        frame_last_o
);

  localparam int ProdW = gse_pkg::SumW + gse_pkg::RecipW;

  logic [gse_pkg::GrayW-1:0] line1_mem [gse_pkg::MaxWidth];
  logic [gse_pkg::GrayW-1:0] line2_mem [gse_pkg::MaxWidth];
  logic [gse_pkg::GrayW-1:0] up1_q, up2_q;
  logic [gse_pkg::ColW-1:0]  clr_q;
  logic [gse_pkg::ColW-1:0]  col_q, col_d;
  logic [gse_pkg::RowW-1:0]  row_q, row_d;
  logic [gse_pkg::SumW-1:0]  sum_q;
  logic                      pix_q;
  logic [gse_pkg::GrayW-1:0] gray_q;
  logic [ProdW-1:0]          prod;
  logic [gse_pkg::GrayW-1:0] win_q [9];
  logic                      border_q, last_q;
  logic [gse_pkg::DimW-1:0]  col_ext, crow, ccol;
  logic                      emit, border, last;
  logic [gse_pkg::AbsW+1:0]  gx, gy;
  logic [gse_pkg::AbsW-1:0]  ax_q, ay_q;
  logic [gse_pkg::MagW-1:0]  sq_q;
  logic [gse_pkg::RootW-1:0] res_q, cand;
  logic [2*gse_pkg::RootW-1:0] cand_sq;
  logic [gse_pkg::IdxW-1:0]  idx_q;

  // line buffer memories, cleared once after reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      line1_mem[clr_q] <= '0;
      line2_mem[clr_q] <= '0;
    end else if (cmd_i.win_update) begin
      line1_mem[col_q] <= gray_q;
      line2_mem[col_q] <= up1_q;
    end
    if (cmd_i.take_item) begin
      up1_q <= line1_mem[col_q];
      up2_q <= line2_mem[col_q];
    end
  end

  // clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // gray conversion: weighted sum, then divide by 100 through a reciprocal
  assign prod = ProdW'(sum_q) * ProdW'(gse_pkg::Recip100);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      sum_q <= gse_pkg::SumW'(red_i) * gse_pkg::SumW'(30)
             + gse_pkg::SumW'(green_i) * gse_pkg::SumW'(58)
             + gse_pkg::SumW'(blue_i) * gse_pkg::SumW'(11);
      pix_q <= !flush_i && (row_q < h_i);
    end
    if (cmd_i.gray_load) begin
      gray_q <= pix_q ? prod[gse_pkg::RecipShift +: gse_pkg::GrayW] : '0;
    end
  end

  // window centre position and border decode
  always_comb begin
    col_ext = gse_pkg::DimW'(col_q);
    emit    = (row_q >= gse_pkg::RowW'(2)) || (row_q == gse_pkg::RowW'(1) && col_q != '0);
    if (col_q == '0) begin
      ccol = w_i - 1'b1;
      crow = row_q - gse_pkg::RowW'(2);
    end else begin
      ccol = col_ext - 1'b1;
      crow = row_q - 1'b1;
    end
    border = (crow == '0) || (crow >= h_i - 1'b1) || (ccol == '0) || (ccol >= w_i - 1'b1);
    last   = (crow >= h_i - 1'b1) && (ccol >= w_i - 1'b1);
    if (col_ext + 1'b1 >= w_i) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
      row_d = row_q;
    end
    if (emit && last) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.win_update) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // 3x3 window shift and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
      border_q <= 1'b0;
      last_q   <= 1'b0;
    end else if (cmd_i.win_update) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= up2_q;
      win_q[5] <= up1_q;
      win_q[8] <= gray_q;
      border_q <= border;
      last_q   <= last;
    end
  end

  // sobel gradients
  always_comb begin
    gx = (12'(win_q[0]) + {win_q[3], 1'b0} + 12'(win_q[6]))
       - (12'(win_q[2]) + {win_q[5], 1'b0} + 12'(win_q[8]));
    gy = (12'(win_q[0]) + {win_q[1], 1'b0} + 12'(win_q[2]))
       - (12'(win_q[6]) + {win_q[7], 1'b0} + 12'(win_q[8]));
  end

  // magnitude: absolute values, sum of squares, then one root bit per cycle
  assign cand    = res_q | (gse_pkg::RootW'(1) << idx_q);
  assign cand_sq = cand * cand;

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad_load) begin
      ax_q <= gx[gse_pkg::AbsW+1] ? gse_pkg::AbsW'(-gx) : gse_pkg::AbsW'(gx);
      ay_q <= gy[gse_pkg::AbsW+1] ? gse_pkg::AbsW'(-gy) : gse_pkg::AbsW'(gy);
    end
    if (cmd_i.sq_load) begin
      sq_q  <= gse_pkg::MagW'(ax_q * ax_q) + gse_pkg::MagW'(ay_q * ay_q);
      res_q <= '0;
      idx_q <= gse_pkg::IdxW'(gse_pkg::RootW - 1);
    end else if (cmd_i.sqrt_step) begin
      if (cand_sq <= (2*gse_pkg::RootW)'(sq_q)) res_q <= cand;
      idx_q <= idx_q - 1'b1;
    end
  end

  // status and result
  assign sts_o.clr_done  = &clr_q;
  assign sts_o.emit      = emit;
  assign sts_o.border    = border;
  assign sts_o.sqrt_done = (idx_q == '0);

  assign edge_value_o = border_q ? '0
                      : (res_q > gse_pkg::RootW'(255)) ? 8'hFF : res_q[7:0];
  assign frame_last_o = last_q;

endmodule

/* rtl/gray_sobel_edge_filter_top.sv */
// top level: configuration registers, output register, controller and datapath
//
//  channel  | direction | handshake            | payload
//  s_axis   | in        | tvalid/tready        | tdata: red, green, blue; tuser: flush
//  m_axis   | out       | tvalid/tready        | tdata: edge_value; tlast: frame_last
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An item with no result passes the idle, gray and window states; a border result then
// takes the output state, and an interior result the gradient, square, bit-by-bit square
// root and output states. After reset both 1024-entry line buffers are cleared first.
// A waiting result sits in the output register while the next item is worked on;
// a stalled output holds the controller only once that next result is ready.
module gray_sobel_edge_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [23:0]                    s_axis_tdata_i,  // red, green, blue
  input  logic                           s_axis_tuser_i,  // flush
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [7:0]                     m_axis_tdata_o,  // edge_value
  output logic                           m_axis_tlast_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gse_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gse_pkg::DimW-1:0]       cfg_data_i
);

  logic [gse_pkg::DimW-1:0] width_q, height_q, w_clamp, h_clamp;
  logic                     cfg_write, restart;
  logic                     out_valid_q, out_free, out_load;
  logic [7:0]               out_data_q;
  logic                     out_last_q;
  logic [7:0]               edge_value;
  logic                     frame_last;
  gse_pkg::dp_cmd_t         cmd;
  gse_pkg::dp_sts_t         sts;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_write && (cfg_index_i == gse_pkg::CfgImageWidth
                                     || cfg_index_i == gse_pkg::CfgImageHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gse_pkg::DimW'(640);
      height_q <= gse_pkg::DimW'(480);
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        gse_pkg::CfgImageWidth:  width_q  <= cfg_data_i;
        gse_pkg::CfgImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_clamp = gse_pkg::clamp_dim(width_q,  gse_pkg::DimW'(gse_pkg::MaxWidth));
  assign h_clamp = gse_pkg::clamp_dim(height_q, gse_pkg::DimW'(gse_pkg::MaxHeight));

  // output register
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= edge_value;
      out_last_q <= frame_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  gse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  gse_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .restart_i    (restart),
    .w_i          (w_clamp),
    .h_i          (h_clamp),
    .red_i        (s_axis_tdata_i[7:0]),
    .green_i      (s_axis_tdata_i[15:8]),
    .blue_i       (s_axis_tdata_i[23:16]),
    .flush_i      (s_axis_tuser_i),
    .edge_value_o (edge_value),
    .frame_last_o (frame_last)
  );

endmodule
